// ----- src/dlf_pkg.sv -----
// dlf_pkg: shared types and constants for the dense layer forward block.
// Holds the item structs, the controller state enum and the datapath command struct.
// No dependencies.
`default_nettype none

package dlf_pkg;

    // Default sizing handed to the top-level parameters
    localparam int MAX_INPUTS_DEF  = 64;
    localparam int MAX_OUTPUTS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Fixed field and register widths
    localparam int VAL_W     = 16;
    localparam int ACC_W     = 40;
    localparam int NIN_W     = 7;
    localparam int NOUT_W    = 5;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_FEED   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUTPUTS = 1'b1;

    // Configuration reset values
    localparam logic [NIN_W-1:0]  NIN_RESET  = 7'd64;
    localparam logic [NOUT_W-1:0] NOUT_RESET = 5'd16;

    // Output saturation bounds in accumulator width
    localparam logic signed [ACC_W-1:0] SAT_MAX = 40'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -40'sd32768;

    typedef struct packed {
        logic [1:0]              operation;
        logic [5:0]              row;
        logic [3:0]              column;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]              out_index;
        logic signed [VAL_W-1:0] out_value;
        logic                    last_output;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_WAIT,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic wr_weight;
        logic wr_bias;
        logic load_x;
        logic mac_issue;
        logic emit_issue;
        logic last;
        logic clear_acc;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- src/dense_layer_forward.sv -----
// dense_layer_forward: top level of the Q8.8 fully connected layer.
// Depends on dlf_pkg, dlf_ctrl, dlf_datapath (and dlf_ram below it).
//
// Usage:
//  - Input channel: a transaction is taken on a rising edge with start high and
//    busy low. item.operation selects weight write, bias write or feed of the
//    next input element; operation 3 is dropped.
//  - Weight and bias writes leave busy low.
//  - A feed runs one shared 16x16 multiplier over the accumulator RAM, one
//    output neuron per cycle; busy stays high until the pipeline has drained,
//    and no new feed is taken until busy is low again.
//  - The feed that completes a vector then streams num_outputs results, one
//    per cycle on result / result_strobe, index 0 first, last one marked with
//    last_output; busy falls at the edge ending the last one.
//  - Results are single-cycle strobes; the receiver cannot stall them.
//  - Config port: wr_en / wr_index / wr_data write num_inputs (0) and
//    num_outputs (1) with no wait; write only while busy is low.
//  - Reset (rst_n, async low): controller idle, element count and accumulators
//    cleared, registers at 64 / 16. Weight and bias RAMs are not cleared.
`default_nettype none

module dense_layer_forward #(
    parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS_DEF,
    parameter int FRAC_BITS   = dlf_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  dlf_pkg::in_item_t             item,
    output logic                          busy,
    output dlf_pkg::out_item_t            result,
    output logic                          result_strobe,
    input  logic                          wr_en,
    input  logic [dlf_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [dlf_pkg::CFG_W-1:0]     wr_data
);

    localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    // Controller -> datapath commands; datapath reports pipeline drained
    dlf_pkg::dp_cmd_t cmd;
    logic [OW-1:0]    idx;      // output neuron being issued
    logic [IW-1:0]    row_idx;  // weight row of the element being fed
    logic             pipe_empty;

    dlf_ctrl #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (item.operation),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .pipe_empty (pipe_empty),
        .busy       (busy),
        .cmd        (cmd),
        .idx        (idx),
        .row_idx    (row_idx)
    );

    // MAC pipeline: RAM read, multiply, accumulate write-back;
    // emit pipeline: RAM read + bias add, shift/saturate, output register
    dlf_datapath #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .idx           (idx),
        .row_idx       (row_idx),
        .pipe_empty    (pipe_empty),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

`default_nettype wire

// ----- src/dlf_ram.sv -----
// dlf_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module dlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/dlf_ctrl.sv -----
// dlf_ctrl: controller FSM, configuration registers and element counter.
// Depends on dlf_pkg.
`default_nettype none

module dlf_ctrl #(
    parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS_DEF,
    localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
    localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [1:0]                     operation,
    input  logic                           wr_en,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [dlf_pkg::CFG_W-1:0]      wr_data,
    input  logic                           pipe_empty,
    output logic                           busy,
    output dlf_pkg::dp_cmd_t               cmd,
    output logic [OW-1:0]                  idx,
    output logic [IW-1:0]                  row_idx
);

    dlf_pkg::state_t state_reg, state_next;
    logic [OW-1:0]                 j_reg, j_next;
    logic [dlf_pkg::NIN_W-1:0]     er_reg, er_next;
    logic                          done_reg, done_next;
    logic [IW-1:0]                 row_reg, row_next;
    logic [dlf_pkg::NIN_W-1:0]     num_in_reg;
    logic [dlf_pkg::NOUT_W-1:0]    num_out_reg;

    logic [dlf_pkg::NIN_W-1:0]     eff_in;
    logic [dlf_pkg::NOUT_W-1:0]    eff_out;
    logic [OW-1:0]                 last_j;
    logic [dlf_pkg::NIN_W-1:0]     er_plus;
    logic [IW-1:0]                 row_sel;
    logic                          at_last;

    // Effective register values: zero acts as one, clamp at the maxima
    always_comb
    begin
        if (num_in_reg == '0)
            eff_in = dlf_pkg::NIN_W'(1);
        else if (int'(num_in_reg) > MAX_INPUTS)
            eff_in = dlf_pkg::NIN_W'(MAX_INPUTS);
        else
            eff_in = num_in_reg;

        if (num_out_reg == '0)
            eff_out = dlf_pkg::NOUT_W'(1);
        else if (int'(num_out_reg) > MAX_OUTPUTS)
            eff_out = dlf_pkg::NOUT_W'(MAX_OUTPUTS);
        else
            eff_out = num_out_reg;

        if (int'(er_reg) >= MAX_INPUTS - 1)
            row_sel = IW'(MAX_INPUTS - 1);
        else
            row_sel = IW'(er_reg);
    end

    assign last_j  = OW'(eff_out - dlf_pkg::NOUT_W'(1));
    assign er_plus = er_reg + dlf_pkg::NIN_W'(1);
    assign at_last = (j_reg == last_j);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_in_reg  <= dlf_pkg::NIN_RESET;
            num_out_reg <= dlf_pkg::NOUT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                dlf_pkg::CFG_NUM_INPUTS:  num_in_reg  <= wr_data;
                dlf_pkg::CFG_NUM_OUTPUTS: num_out_reg <= wr_data[dlf_pkg::NOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlf_pkg::ST_IDLE;
            j_reg     <= '0;
            er_reg    <= '0;
            done_reg  <= 1'b0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            er_reg    <= er_next;
            done_reg  <= done_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        er_next    = er_reg;
        done_next  = done_reg;
        row_next   = row_reg;
        cmd        = '0;

        case (state_reg)
            dlf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        dlf_pkg::OP_WEIGHT: cmd.wr_weight = 1'b1;
                        dlf_pkg::OP_BIAS:   cmd.wr_bias   = 1'b1;
                        dlf_pkg::OP_FEED:
                        begin
                            cmd.load_x = 1'b1;
                            row_next   = row_sel;
                            done_next  = (er_plus >= eff_in);
                            er_next    = (er_plus >= eff_in) ? '0 : er_plus;
                            j_next     = '0;
                            state_next = dlf_pkg::ST_MAC;
                        end
                        default: ;
                    endcase
                end
            end

            dlf_pkg::ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.last      = at_last;
                if (at_last)
                begin
                    j_next     = '0;
                    state_next = dlf_pkg::ST_MAC_WAIT;
                end
                else
                begin
                    j_next = j_reg + OW'(1);
                end
            end

            dlf_pkg::ST_MAC_WAIT:
            begin
                if (pipe_empty)
                    state_next = done_reg ? dlf_pkg::ST_EMIT : dlf_pkg::ST_IDLE;
            end

            dlf_pkg::ST_EMIT:
            begin
                cmd.emit_issue = 1'b1;
                cmd.last       = at_last;
                if (at_last)
                begin
                    j_next     = '0;
                    state_next = dlf_pkg::ST_EMIT_WAIT;
                end
                else
                begin
                    j_next = j_reg + OW'(1);
                end
            end

            dlf_pkg::ST_EMIT_WAIT:
            begin
                if (pipe_empty)
                begin
                    cmd.clear_acc = 1'b1;
                    state_next    = dlf_pkg::ST_IDLE;
                end
            end

            default: state_next = dlf_pkg::ST_IDLE;
        endcase
    end

    assign busy    = (state_reg != dlf_pkg::ST_IDLE);
    assign idx     = j_reg;
    assign row_idx = row_reg;

endmodule

`default_nettype wire

// ----- src/dlf_datapath.sv -----
// dlf_datapath: weight/bias/accumulator RAMs, shared multiply-accumulate pipeline
// and the shift/saturate output stage. Depends on dlf_pkg and dlf_ram.
`default_nettype none

module dlf_datapath #(
    parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS_DEF,
    parameter int FRAC_BITS   = dlf_pkg::FRAC_BITS_DEF,
    localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
    localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
    localparam int WD  = MAX_INPUTS * MAX_OUTPUTS,
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dlf_pkg::in_item_t  item,
    input  dlf_pkg::dp_cmd_t   cmd,
    input  logic [OW-1:0]      idx,
    input  logic [IW-1:0]      row_idx,
    output logic               pipe_empty,
    output dlf_pkg::out_item_t result,
    output logic               result_strobe
);

    localparam int VW = dlf_pkg::VAL_W;
    localparam int AW = dlf_pkg::ACC_W;

    logic signed [VW-1:0]   x_reg;

    logic                   w_we;
    logic [WAW-1:0]         w_waddr, w_raddr;
    logic [VW-1:0]          w_rdata;
    logic                   b_we;
    logic [VW-1:0]          b_rdata;
    logic                   a_we;
    logic [AW-1:0]          a_rdata;
    logic [AW-1:0]          a_wdata;

    logic [MAX_OUTPUTS-1:0] acc_vld_reg;

    logic                   s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [OW-1:0]          s1_idx_reg;
    logic                   s2_valid_reg, s2_emit_reg, s2_last_reg;
    logic [OW-1:0]          s2_idx_reg;

    logic signed [2*VW-1:0] prod_reg;
    logic signed [AW-1:0]   acc_q_reg;
    logic signed [AW-1:0]   acc_cur, bias_al, acc_q_next;
    logic signed [AW-1:0]   shifted;
    logic signed [VW-1:0]   sat_val;

    dlf_pkg::out_item_t     result_reg;
    logic                   strobe_reg;

    // Weight store, address row * MAX_OUTPUTS + column
    assign w_we    = cmd.wr_weight && (int'(item.row) < MAX_INPUTS)
                     && (int'(item.column) < MAX_OUTPUTS);
    assign w_waddr = WAW'(int'(item.row) * MAX_OUTPUTS + int'(item.column));
    assign w_raddr = WAW'(int'(row_idx) * MAX_OUTPUTS + int'(idx));

    dlf_ram #(.WIDTH(VW), .DEPTH(WD)) u_wram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (item.value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    assign b_we = cmd.wr_bias && (int'(item.column) < MAX_OUTPUTS);

    dlf_ram #(.WIDTH(VW), .DEPTH(MAX_OUTPUTS)) u_bram (
        .clk   (clk),
        .we    (b_we),
        .waddr (OW'(item.column)),
        .wdata (item.value),
        .raddr (idx),
        .rdata (b_rdata)
    );

    // Accumulators: written back in stage 2 of a MAC pass
    assign a_we = s2_valid_reg && !s2_emit_reg;

    dlf_ram #(.WIDTH(AW), .DEPTH(MAX_OUTPUTS)) u_aram (
        .clk   (clk),
        .we    (a_we),
        .waddr (s2_idx_reg),
        .wdata (a_wdata),
        .raddr (idx),
        .rdata (a_rdata)
    );

    // Stage 1: unwritten accumulators read as zero; emit adds aligned bias
    always_comb
    begin
        acc_cur    = acc_vld_reg[s1_idx_reg] ? $signed(a_rdata) : '0;
        bias_al    = $signed({{(AW - VW){b_rdata[VW-1]}}, b_rdata}) <<< FRAC_BITS;
        acc_q_next = s1_emit_reg ? (acc_cur + bias_al) : acc_cur;
    end

    // Stage 2: accumulate, or floor-shift and saturate
    always_comb
    begin
        a_wdata = acc_q_reg + {{(AW - 2*VW){prod_reg[2*VW-1]}}, prod_reg};
        shifted = acc_q_reg >>> FRAC_BITS;
        if (shifted > dlf_pkg::SAT_MAX)
            sat_val = VW'(dlf_pkg::SAT_MAX);
        else if (shifted < dlf_pkg::SAT_MIN)
            sat_val = VW'(dlf_pkg::SAT_MIN);
        else
            sat_val = shifted[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= item.value;
        prod_reg  <= x_reg * $signed(w_rdata);
        acc_q_reg <= acc_q_next;
        s1_emit_reg <= cmd.emit_issue;
        s1_last_reg <= cmd.last;
        s1_idx_reg  <= idx;
        s2_emit_reg <= s1_emit_reg;
        s2_last_reg <= s1_last_reg;
        s2_idx_reg  <= s1_idx_reg;
        result_reg.out_index   <= 4'(s2_idx_reg);
        result_reg.out_value   <= sat_val;
        result_reg.last_output <= s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            acc_vld_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.mac_issue || cmd.emit_issue;
            s2_valid_reg <= s1_valid_reg;
            strobe_reg   <= s2_valid_reg && s2_emit_reg;
            if (cmd.clear_acc)
                acc_vld_reg <= '0;
            else if (a_we)
                acc_vld_reg[s2_idx_reg] <= 1'b1;
        end
    end

    assign pipe_empty    = !s1_valid_reg && !s2_valid_reg;
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

`default_nettype wire

// ----- src/dlf_checker.sv -----
// dlf_assertions: port-level assertions for dense_layer_forward, attached by bind.
// Depends on dlf_pkg and dense_layer_forward.
`default_nettype none

module dlf_assertions (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input dlf_pkg::in_item_t  item,
    input logic               busy,
    input dlf_pkg::out_item_t result,
    input logic               result_strobe
);

    // Results only stream while the block is still busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result transaction while idle");

    // Results of a vector come back to back with rising index
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last_output |=>
            result_strobe && (result.out_index == 4'($past(result.out_index) + 4'd1)))
        else $error("result stream broken or out of order");

    // Nothing follows the marked last result
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last_output |=> !result_strobe)
        else $error("result transaction after last_output");

    // A feed makes the block busy; any other transaction does not
    a_feed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.operation == dlf_pkg::OP_FEED) |=> busy)
        else $error("feed accepted without going busy");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.operation != dlf_pkg::OP_FEED) |=> !busy)
        else $error("store write left the block busy");

endmodule

bind dense_layer_forward dlf_assertions u_dlf_checker (.*);

`default_nettype wire
